>>> rtl/jlks_pkg.sv
// ----------------------------------------------------------------------------
// jlks_pkg
// Shared types and constants for the JSON level key scanner: word formats,
// register indexes, character codes and the scanner flag set.
// ----------------------------------------------------------------------------
`default_nettype none

package jlks_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_ANY_DEPTH_MODE    = 2'd0;
  localparam logic [1:0] CFG_WANTED_KEY_LOW    = 2'd1;
  localparam logic [1:0] CFG_WANTED_KEY_HIGH   = 2'd2;
  localparam logic [1:0] CFG_WANTED_KEY_LENGTH = 2'd3;

  localparam int CFG_DATA_BITS = 64;

  // Character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  localparam logic [7:0] KEY_LEN_MAX = 8'hFF;

  // Input word
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic              key_found;
    logic [7:0]        key_length;
    logic              key_match;
    logic              first_match_res;
    logic signed [7:0] nesting_depth;
  } out_word_t;

  // Scanner flags and key counter (depth is kept apart, its width varies)
  typedef struct packed {
    logic       leading_phase;
    logic       inside_string;
    logic       escape_pending;
    logic       slash_seen;
    logic       in_comment;
    logic       key_level_ok;
    logic       awaiting_colon;
    logic       key_equal_so_far;
    logic       already_matched;
    logic [7:0] key_byte_count;
  } scan_flags_t;

  localparam scan_flags_t FLAGS_CLEAR = '{
    leading_phase:    1'b1,
    inside_string:    1'b0,
    escape_pending:   1'b0,
    slash_seen:       1'b0,
    in_comment:       1'b0,
    key_level_ok:     1'b0,
    awaiting_colon:   1'b0,
    key_equal_so_far: 1'b1,
    already_matched:  1'b0,
    key_byte_count:   8'd0
  };

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

endpackage

`default_nettype wire

>>> rtl/json_level_key_scanner.sv
// ----------------------------------------------------------------------------
// json_level_key_scanner
// Streaming JSON key finder: scans one document byte per word, tracks
// nesting, strings, escapes and line comments, and flags keys at the colon.
// ----------------------------------------------------------------------------
//
//   channel  ports                        word
//   -------  ---------------------------  ---------------------------------
//   input    in_valid in_ready in_data    text_byte, last_byte
//   result   out_valid out_ready out_data key_found .. nesting_depth
//   config   cfg_valid cfg_ready          cfg_index (2b), cfg_data (64b)
//
// One byte per cycle: the scanner state and the result register are updated
// in the same cycle the byte is accepted; the result shows in the next cycle.
// The result register acts as the output stage, so a new byte is taken while
// a result is being taken in the same cycle. A stall on out_ready holds the
// result and stops input. Synchronous reset clears the scanner state, the
// config registers and out_valid; config writes are taken every cycle.
//
`default_nettype none

module json_level_key_scanner
  import jlks_pkg::*;
#(
  parameter int KEY_BYTES  = 16,
  parameter int DEPTH_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire in_word_t                 in_data,

  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      out_word_t                out_data,

  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int IdxBits  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int WideBits = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;

  localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [WideBits-1:0]   OutMax   = WideBits'(127);
  localparam logic signed [WideBits-1:0]   OutMin   = -WideBits'(128);
  localparam logic [7:0]                   KeyBytesW = 8'(KEY_BYTES);

  // Configuration registers
  logic             any_depth_r;
  logic [7:0]       wanted_r [KEY_BYTES];
  logic [4:0]       wanted_len_r;

  // Scanner state
  scan_flags_t                   flags_r, flags_nxt;
  logic signed [DEPTH_BITS-1:0]  depth_r, depth_nxt;

  // Result register
  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  logic       in_fire;
  logic [7:0] b;
  logic [7:0] want_byte;
  logic       key_miss;
  logic signed [WideBits-1:0] depth_wide;

  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.text_byte;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_depth_r  <= 1'b0;
      wanted_len_r <= 5'd0;
      for (int i = 0; i < KEY_BYTES; i++) begin
        wanted_r[i] <= 8'd0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ANY_DEPTH_MODE:    any_depth_r  <= cfg_data[0];
        CFG_WANTED_KEY_LENGTH: wanted_len_r <= cfg_data[4:0];
        CFG_WANTED_KEY_LOW: begin
          for (int i = 0; i < KEY_BYTES; i++) begin
            if (i < 8) begin
              wanted_r[i] <= cfg_data[8*(i%8) +: 8];
            end
          end
        end
        CFG_WANTED_KEY_HIGH: begin
          for (int i = 0; i < KEY_BYTES; i++) begin
            if (i >= 8) begin
              wanted_r[i] <= cfg_data[8*(i%8) +: 8];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Compare the next key byte against the wanted key
  assign want_byte = (flags_r.key_byte_count < KeyBytesW)
                   ? wanted_r[flags_r.key_byte_count[IdxBits-1:0]] : 8'd0;
  assign key_miss  = (flags_r.key_byte_count >= {3'd0, wanted_len_r}) |
                     (flags_r.key_byte_count >= KeyBytesW) |
                     (want_byte != b);

  // Scan one byte
  always_comb begin
    logic consumed;
    logic handled;
    logic is_match;
    flags_nxt    = flags_r;
    depth_nxt    = depth_r;
    out_data_nxt = '0;
    consumed     = 1'b0;
    handled      = 1'b0;
    is_match     = 1'b0;
    depth_wide   = '0;

    if (b == CH_NUL) begin
      flags_nxt = FLAGS_CLEAR;
      depth_nxt = '0;
    end else begin
      // Skip leading whitespace and one opening brace
      if (flags_r.leading_phase) begin
        if (is_space(b)) begin
          consumed = 1'b1;
        end else begin
          flags_nxt.leading_phase = 1'b0;
          consumed = (b == CH_LBRACE);
        end
      end

      if (!consumed) begin
        if (flags_r.inside_string) begin
          // Inside a string: escapes, closing quote, key bytes
          if (!flags_r.escape_pending && (b == CH_QUOTE)) begin
            flags_nxt.inside_string  = 1'b0;
            flags_nxt.awaiting_colon = 1'b1;
            flags_nxt.key_level_ok   = any_depth_r | (depth_r == '0);
          end else begin
            flags_nxt.escape_pending   = ~flags_r.escape_pending & (b == CH_BACKSLASH);
            flags_nxt.key_equal_so_far = flags_r.key_equal_so_far & ~key_miss;
            if (flags_r.key_byte_count != KEY_LEN_MAX) begin
              flags_nxt.key_byte_count = flags_r.key_byte_count + 8'd1;
            end
          end
        end else if (flags_r.in_comment) begin
          // Drop comment bytes up to the newline
          if (b == CH_LF) begin
            flags_nxt.in_comment = 1'b0;
          end
        end else if (flags_r.slash_seen && (b == CH_SLASH)) begin
          flags_nxt.slash_seen = 1'b0;
          flags_nxt.in_comment = 1'b1;
        end else begin
          flags_nxt.slash_seen = 1'b0;

          // Wait for the colon after a closing quote
          if (flags_r.awaiting_colon) begin
            if (is_space(b)) begin
              handled = 1'b1;
            end else begin
              flags_nxt.awaiting_colon = 1'b0;
              if (b == CH_COLON) begin
                handled = 1'b1;
                if (flags_r.key_level_ok) begin
                  is_match = flags_r.key_equal_so_far &
                             (flags_r.key_byte_count == {3'd0, wanted_len_r});
                  out_data_nxt.key_found       = 1'b1;
                  out_data_nxt.key_length      = flags_r.key_byte_count;
                  out_data_nxt.key_match       = is_match;
                  out_data_nxt.first_match_res = is_match & ~flags_r.already_matched;
                  if (is_match) begin
                    flags_nxt.already_matched = 1'b1;
                  end
                end
              end
            end
          end

          // Structural bytes
          if (!handled) begin
            priority if (b == CH_QUOTE) begin
              flags_nxt.inside_string    = 1'b1;
              flags_nxt.escape_pending   = 1'b0;
              flags_nxt.key_byte_count   = 8'd0;
              flags_nxt.key_equal_so_far = 1'b1;
            end else if ((b == CH_LBRACE) || (b == CH_LBRACKET)) begin
              if (depth_r != DepthMax) begin
                depth_nxt = depth_r + DEPTH_BITS'(1);
              end
            end else if ((b == CH_RBRACE) || (b == CH_RBRACKET)) begin
              if (depth_r != DepthMin) begin
                depth_nxt = depth_r - DEPTH_BITS'(1);
              end
            end else if (b == CH_SLASH) begin
              flags_nxt.slash_seen = 1'b1;
            end else begin
            end
          end
        end
      end

      // Report depth after this byte, clamped to eight bits
      depth_wide = WideBits'(depth_nxt);
      priority if (depth_wide > OutMax) begin
        out_data_nxt.nesting_depth = 8'sd127;
      end else if (depth_wide < OutMin) begin
        out_data_nxt.nesting_depth = -8'sd128;
      end else begin
        out_data_nxt.nesting_depth = depth_wide[7:0];
      end

      // End of document restarts the scan
      if (in_data.last_byte) begin
        flags_nxt = FLAGS_CLEAR;
        depth_nxt = '0;
      end
    end
  end

  // Advance scanner state on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= FLAGS_CLEAR;
      depth_r <= '0;
    end else if (in_fire) begin
      flags_r <= flags_nxt;
      depth_r <= depth_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  a_first_implies_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.first_match_res |-> out_data_r.key_match)
    else $error("first match flagged without a match");

  a_match_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.key_match |-> out_data_r.key_found)
    else $error("key match flagged without a found key");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.key_found |->
      out_data_r.key_length == 8'd0 && !out_data_r.first_match_res)
    else $error("key fields set without a found key");

  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.text_byte == CH_NUL |=>
      out_valid_r && !out_data_r.key_found && out_data_r.nesting_depth == 8'sd0 &&
      flags_r.leading_phase && depth_r == '0)
    else $error("zero byte did not restart the scan");

  a_leading_clean: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.leading_phase |-> depth_r == '0 && !flags_r.inside_string &&
      !flags_r.awaiting_colon)
    else $error("scan state set before the document started");

endmodule

`default_nettype wire

>>> tb/json_level_key_scanner_tb.sv
// ----------------------------------------------------------------------------
// json_level_key_scanner_tb
// Self-checking bench for the JSON level key scanner. A short stimulus table
// walks the basic key, escape, comment and end-of-document cases, then
// generated documents (nested objects, comments, escapes, noise, deep nesting
// and long keys) run under six register settings. An in-bench scan model
// predicts all but fixed-row results; the checker compares each field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_level_key_scanner_tb
  import jlks_pkg::*;
();

  localparam int KEY_SLOTS = 16;
  localparam int DEPTH_W   = 8;
  localparam int DEPTH_HI  = (1 << (DEPTH_W - 1)) - 1;
  localparam int DEPTH_LO  = -DEPTH_HI - 1;
  localparam int PHASE_WORDS = 130;

  localparam out_word_t NO_KEY_TOP = '0;
  localparam out_word_t AB_FIRST = '{key_found: 1'b1, key_length: 8'd2, key_match: 1'b1,
                                     first_match_res: 1'b1, nesting_depth: 8'sd0};
  localparam out_word_t AB_AGAIN = '{key_found: 1'b1, key_length: 8'd2, key_match: 1'b1,
                                     first_match_res: 1'b0, nesting_depth: 8'sd0};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fixed_exp;
    out_word_t  want;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  // register mirror
  logic        w_mode = 1'b0;
  logic [63:0] w_lo   = '0;
  logic [63:0] w_hi   = '0;
  logic [4:0]  w_len  = '0;

  // scan model state
  int   depth_lvl;
  bit   in_str, esc_next, lead_ws, slash_prev, in_cmt;
  bit   colon_ok, colon_wait, k_equal, matched_once;
  int   k_count;

  out_word_t results_due[$];
  out_word_t due_w;
  in_word_t  doc_q[$];

  int  errors = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  keys_seen = 0;
  int  keys_matched = 0;
  int  docs_built = 0;
  int  settings_applied = 0;
  int  burst_left = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_stalls = 1'b1;
  bit  rx_on = 1'b0;
  int  rx_left = 0;

  dir_row_t dir_rows [27] = '{
    '{CH_SPACE,     1'b0, 1'b1, NO_KEY_TOP},  // leading blank
    '{CH_LBRACE,    1'b0, 1'b1, NO_KEY_TOP},  // outer brace swallowed
    '{CH_QUOTE,     1'b0, 1'b0, NO_KEY_TOP},
    '{8'h61,        1'b0, 1'b0, NO_KEY_TOP},  // a
    '{8'h62,        1'b0, 1'b0, NO_KEY_TOP},  // b
    '{CH_QUOTE,     1'b0, 1'b0, NO_KEY_TOP},
    '{CH_TAB,       1'b0, 1'b0, NO_KEY_TOP},  // blank between key and colon
    '{CH_COLON,     1'b0, 1'b1, AB_FIRST},
    '{CH_QUOTE,     1'b0, 1'b0, NO_KEY_TOP},
    '{8'h61,        1'b0, 1'b0, NO_KEY_TOP},
    '{8'h62,        1'b0, 1'b0, NO_KEY_TOP},
    '{CH_QUOTE,     1'b0, 1'b0, NO_KEY_TOP},
    '{CH_COLON,     1'b0, 1'b1, AB_AGAIN},    // match, but not the first
    '{CH_LBRACKET,  1'b0, 1'b0, NO_KEY_TOP},
    '{CH_QUOTE,     1'b0, 1'b0, NO_KEY_TOP},
    '{CH_BACKSLASH, 1'b0, 1'b0, NO_KEY_TOP},
    '{CH_QUOTE,     1'b0, 1'b0, NO_KEY_TOP},  // escaped quote stays in string
    '{CH_QUOTE,     1'b0, 1'b0, NO_KEY_TOP},
    '{CH_RBRACKET,  1'b0, 1'b0, NO_KEY_TOP},  // cancels the pending key
    '{CH_SLASH,     1'b0, 1'b0, NO_KEY_TOP},  // lone slash
    '{8'h78,        1'b0, 1'b0, NO_KEY_TOP},  // x
    '{CH_SLASH,     1'b0, 1'b0, NO_KEY_TOP},
    '{CH_SLASH,     1'b0, 1'b0, NO_KEY_TOP},  // line comment opens
    '{CH_COLON,     1'b0, 1'b0, NO_KEY_TOP},
    '{CH_LF,        1'b0, 1'b0, NO_KEY_TOP},  // comment closes
    '{8'hFF,        1'b1, 1'b0, NO_KEY_TOP},  // top byte ends the document
    '{CH_NUL,       1'b0, 1'b1, NO_KEY_TOP}   // zero byte
  };

  json_level_key_scanner #(
    .KEY_BYTES  (KEY_SLOTS),
    .DEPTH_BITS (DEPTH_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- scan model

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic [7:0] key_byte_at(input int i);
    return (i < 8) ? w_lo[8*i +: 8] : w_hi[8*(i-8) +: 8];
  endfunction

  function automatic void restart_doc();
    depth_lvl    = 0;
    in_str       = 1'b0;
    esc_next     = 1'b0;
    lead_ws      = 1'b1;
    slash_prev   = 1'b0;
    in_cmt       = 1'b0;
    colon_ok     = 1'b0;
    colon_wait   = 1'b0;
    k_count      = 0;
    k_equal      = 1'b1;
    matched_once = 1'b0;
  endfunction

  function automatic void take_key_byte(input logic [7:0] b);
    if (k_count >= int'(w_len) || k_count >= KEY_SLOTS) k_equal = 1'b0;
    else if (key_byte_at(k_count) != b) k_equal = 1'b0;
    if (k_count < 255) k_count++;
  endfunction

  function automatic out_word_t scan_byte(input logic [7:0] b, input logic last);
    out_word_t r;
    bit        done;
    int        d;
    r    = '0;
    done = 1'b0;
    if (b == CH_NUL) begin
      restart_doc();
      return r;
    end
    // skip leading blanks, swallow one opening brace
    if (lead_ws) begin
      if (is_blank(b)) begin
        done = 1'b1;
      end else begin
        lead_ws = 1'b0;
        if (b == CH_LBRACE) done = 1'b1;
      end
    end
    // string body: count raw bytes, escapes included
    if (!done && in_str) begin
      done = 1'b1;
      if (esc_next) begin
        esc_next = 1'b0;
        take_key_byte(b);
      end else if (b == CH_BACKSLASH) begin
        esc_next = 1'b1;
        take_key_byte(b);
      end else if (b == CH_QUOTE) begin
        in_str     = 1'b0;
        colon_wait = 1'b1;
        colon_ok   = w_mode || depth_lvl == 0;
      end else begin
        take_key_byte(b);
      end
    end
    // drop comment text up to the newline
    if (!done && in_cmt) begin
      done = 1'b1;
      if (b == CH_LF) in_cmt = 1'b0;
    end
    if (!done && slash_prev && b == CH_SLASH) begin
      slash_prev = 1'b0;
      in_cmt     = 1'b1;
      done       = 1'b1;
    end
    if (!done) slash_prev = 1'b0;
    // closed string waits for a colon; anything else cancels it
    if (!done && colon_wait) begin
      if (is_blank(b)) begin
        done = 1'b1;
      end else begin
        colon_wait = 1'b0;
        if (b == CH_COLON) begin
          done = 1'b1;
          if (colon_ok) begin
            r.key_found       = 1'b1;
            r.key_length      = 8'(k_count);
            r.key_match       = k_equal && (k_count == int'(w_len));
            r.first_match_res = r.key_match && !matched_once;
            if (r.key_match) matched_once = 1'b1;
          end
        end
      end
    end
    if (!done) begin
      case (b)
        CH_QUOTE: begin
          in_str   = 1'b1;
          esc_next = 1'b0;
          k_count  = 0;
          k_equal  = 1'b1;
        end
        CH_LBRACE, CH_LBRACKET: if (depth_lvl < DEPTH_HI) depth_lvl++;
        CH_RBRACE, CH_RBRACKET: if (depth_lvl > DEPTH_LO) depth_lvl--;
        CH_SLASH: slash_prev = 1'b1;
        default: ;
      endcase
    end
    d = depth_lvl;
    if (d > 127) d = 127;
    if (d < -128) d = -128;
    r.nesting_depth = 8'(d);
    if (last) restart_doc();
    return r;
  endfunction

  // ---------------------------------------------------------------- channels

  // send one byte word, hold it until taken, then queue its expected result
  task automatic send_word(input in_word_t w, input bit use_fixed, input out_word_t fixed_w);
    out_word_t predicted;
    if (tx_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = scan_byte(w.text_byte, w.last_byte);
    results_due.push_back(use_fixed ? fixed_w : predicted);
    if (burst_left > 0) burst_left--;
    words_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding result
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ANY_DEPTH_MODE:    w_mode = val[0];
      CFG_WANTED_KEY_LOW:    w_lo   = val;
      CFG_WANTED_KEY_HIGH:   w_hi   = val;
      CFG_WANTED_KEY_LENGTH: w_len  = val[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [63:0] mode_v, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [63:0] len_v);
    write_reg(CFG_ANY_DEPTH_MODE, mode_v);
    write_reg(CFG_WANTED_KEY_LOW, lo);
    write_reg(CFG_WANTED_KEY_HIGH, hi);
    write_reg(CFG_WANTED_KEY_LENGTH, len_v);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------- documents

  // printable or high byte that neither ends a string nor escapes
  function automatic logic [7:0] key_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 255));
    while (c == CH_QUOTE || c == CH_BACKSLASH) c = 8'($urandom_range(32, 255));
    return c;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    doc_q.push_back('{text_byte: b, last_byte: 1'b0});
  endtask

  task automatic pad();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: put_byte(CH_SPACE);
        1: put_byte(CH_TAB);
        2: put_byte(CH_LF);
        default: put_byte(CH_CR);
      endcase
    end
  endtask

  task automatic make_key(output logic [63:0] lo, output logic [63:0] hi);
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = key_char();
      hi[8*i +: 8] = key_char();
    end
  endtask

  // quoted key: mostly the wanted key or near misses, some escapes and junk
  task automatic add_key(input bit long_key);
    int n, kind, alt;
    logic [7:0] c;
    n    = (int'(w_len) > KEY_SLOTS) ? KEY_SLOTS : int'(w_len);
    kind = long_key ? 8 : $urandom_range(0, 7);
    put_byte(CH_QUOTE);
    case (kind)
      0, 1, 2: for (int i = 0; i < n; i++) put_byte(key_byte_at(i));
      3: begin
        alt = (n > 0) ? $urandom_range(0, n - 1) : 0;
        for (int i = 0; i < n; i++) begin
          c = key_byte_at(i);
          if (i == alt && $urandom_range(0, 1)) c = key_char();
          put_byte(c);
        end
        if ($urandom_range(0, 1)) put_byte(key_char());
      end
      4: for (int i = 0; i + 1 < n; i++) put_byte(key_byte_at(i));
      5: repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 2) == 0) begin
          put_byte(CH_BACKSLASH);
          put_byte(8'($urandom_range(1, 255)));
        end else begin
          put_byte(key_char());
        end
      end
      6: repeat ($urandom_range(0, 20)) put_byte(key_char());
      7: repeat ($urandom_range(0, 3)) put_byte(key_char());
      default: repeat ($urandom_range(250, 270)) put_byte(key_char());
    endcase
    put_byte(CH_QUOTE);
  endtask

  task automatic build_doc(input bit long_key);
    int open, members;
    pad();
    if ($urandom_range(0, 4) != 0) put_byte(CH_LBRACE);
    open    = 0;
    members = $urandom_range(1, 6);
    for (int m = 0; m < members; m++) begin
      pad();
      add_key(long_key && m == 0);
      pad();
      if (long_key || $urandom_range(0, 9) != 0) put_byte(CH_COLON);
      else put_byte(8'($urandom_range(1, 255)));
      pad();
      case ($urandom_range(0, 7))
        0: begin
          put_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
          open++;
        end
        1: begin
          if (open > 0) begin
            put_byte(CH_RBRACE);
            open--;
          end else begin
            put_byte(8'h30);
          end
        end
        2: begin
          put_byte(CH_QUOTE);
          repeat ($urandom_range(0, 4)) put_byte(key_char());
          put_byte(CH_QUOTE);
        end
        3: repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(8'h30, 8'h39)));
        4: begin
          put_byte(CH_SLASH);
          put_byte(CH_SLASH);
          put_byte(CH_QUOTE);
          put_byte(CH_COLON);
          repeat ($urandom_range(0, 4)) put_byte(key_char());
          put_byte(CH_LF);
        end
        5: begin
          put_byte(CH_SLASH);
          put_byte(key_char());
        end
        6: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
        default: begin
          put_byte(8'h74);
          put_byte(8'h72);
          put_byte(8'h75);
          put_byte(8'h65);
        end
      endcase
      if ($urandom_range(0, 1)) put_byte(8'h2C);
    end
    repeat (open) put_byte(CH_RBRACKET);
    if ($urandom_range(0, 1)) put_byte(CH_RBRACE);
    // close the document by last flag, zero byte, both, or not at all
    case ($urandom_range(0, 3))
      0: doc_q[doc_q.size() - 1].last_byte = 1'b1;
      1: put_byte(CH_NUL);
      2: doc_q.push_back('{text_byte: CH_NUL, last_byte: 1'b1});
      default: ;
    endcase
    docs_built++;
  endtask

  // drive depth past both saturation points, with a key at each end
  task automatic add_deep_doc();
    repeat (DEPTH_HI + 4) put_byte(CH_LBRACKET);
    add_key(1'b0);
    put_byte(CH_COLON);
    put_byte(8'h31);
    put_byte(CH_NUL);
    repeat (DEPTH_HI + 5) put_byte(CH_RBRACE);
    add_key(1'b0);
    put_byte(CH_COLON);
    doc_q[doc_q.size() - 1].last_byte = 1'b1;
    docs_built++;
  endtask

  task automatic send_doc();
    while (doc_q.size() != 0) send_word(doc_q.pop_front(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------- receiver

  // alternate ready runs and stalls of random length
  always @(negedge clk) begin
    if (!rx_stalls) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_on   = ~rx_on;
        rx_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
      end
      rx_left--;
      out_ready <= rx_on;
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        errors++;
      end else begin
        due_w = results_due.pop_front();
        words_checked++;
        if (due_w.key_found) keys_seen++;
        if (due_w.key_match) keys_matched++;
        if (out_data.key_found !== due_w.key_found) begin
          $error("key_found: expected %0d, got %0d", due_w.key_found, out_data.key_found);
          errors++;
        end
        if (out_data.key_length !== due_w.key_length) begin
          $error("key_length: expected %0d, got %0d", due_w.key_length, out_data.key_length);
          errors++;
        end
        if (out_data.key_match !== due_w.key_match) begin
          $error("key_match: expected %0d, got %0d", due_w.key_match, out_data.key_match);
          errors++;
        end
        if (out_data.first_match_res !== due_w.first_match_res) begin
          $error("first_match_res: expected %0d, got %0d",
                 due_w.first_match_res, out_data.first_match_res);
          errors++;
        end
        if (out_data.nesting_depth !== due_w.nesting_depth) begin
          $error("nesting_depth: expected %0d, got %0d",
                 due_w.nesting_depth, out_data.nesting_depth);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    logic [63:0] rk_lo, rk_hi;
    int          phase_start;
    restart_doc();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      make_key(rk_lo, rk_hi);
      tx_gaps   = (ph != 2);
      rx_stalls = (ph != 2);
      case (ph)
        0: set_config(64'd0, 64'h6261, 64'd0, 64'd2);
        1: set_config(64'd1, rk_lo, rk_hi, 64'($urandom_range(1, KEY_SLOTS)));
        2: set_config(64'd0, '1, '1, 64'd16);
        3: set_config(64'd1, 64'd0, 64'd0, 64'd0);
        4: set_config(64'd0, rk_lo, rk_hi, '1);
        default: set_config('1, rk_lo, rk_hi, 64'($urandom_range(1, 8)));
      endcase

      // walk the stimulus table once, right after reset
      if (ph == 0) begin
        foreach (dir_rows[i]) begin
          send_word('{text_byte: dir_rows[i].ch, last_byte: dir_rows[i].last},
                    dir_rows[i].fixed_exp, dir_rows[i].want);
        end
      end

      if (ph == 1) begin
        add_deep_doc();
        send_doc();
      end

      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        build_doc(ph == 2 && words_sent == phase_start);
        send_doc();
        if ($urandom_range(0, 14) == 0) hold_until_drained();
      end
      hold_until_drained();
    end

    // wait for any stray result word
    repeat (4) @(posedge clk);
    $display("Scanned %0d bytes in %0d generated documents under %0d register settings.",
             words_sent, docs_built, settings_applied);
    $display("Checked %0d result words: %0d keys found, %0d matching the wanted key.",
             words_checked, keys_seen, keys_matched);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> json_level_key_scanner.f
rtl/jlks_pkg.sv
rtl/json_level_key_scanner.sv
tb/json_level_key_scanner_tb.sv
